FILE: src/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types, constants and round functions of the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
`default_nettype none
package sha_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned NumHash = 8;
  localparam int unsigned NumRnd  = 64;
  localparam int unsigned LenW    = 64;
  localparam logic [7:0]  PadByte = 8'h80;
  localparam logic [5:0]  LenPos  = 6'd56;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       has_byte;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  // byte source selection for the block buffer
  typedef enum logic [1:0] {
    SRC_MSG,
    SRC_PAD,
    SRC_ZERO
  } byte_src_t;

  // controller commands
  typedef struct packed {
    logic      msg_init;    // reset hash, count, fill for a new message
    logic      put_byte;    // write one byte at the fill position
    byte_src_t src;
    logic      count_byte;  // bump the running byte count
    logic      put_len;     // write the bit length into words 14 and 15
    logic      comp_start;  // load working vars and begin rounds
    logic      round_step;  // one round
    logic      comp_fold;   // add working vars into hash words
  } sha_cmd_t;

  // datapath status
  typedef struct packed {
    logic [5:0] fill;
    logic [5:0] rnd;
  } sha_sts_t;

  localparam logic [31:0] InitH [NumHash] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] RoundK [NumRnd] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

endpackage
`default_nettype wire

FILE: src/sha_ctrl.sv
// ----------------------------------------------------------------------------
// sha_ctrl
// Sequencer: accepts items, drives padding, rounds and digest output.
// ----------------------------------------------------------------------------
`default_nettype none
module sha_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire sha_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [2:0]             out_idx,
  output sha_pkg::sha_cmd_t      cmd,
  input  wire sha_pkg::sha_sts_t sts
);
  import sha_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROUND,
    S_FOLD,
    S_PAD,
    S_ZERO,
    S_LEN,
    S_OUT
  } state_t;

  state_t     state_r, state_nxt;
  logic       fin_r, fin_nxt;      // compression belongs to the finish
  logic       last_r, last_nxt;    // finish pending after a byte fills a block
  logic       pad_r, pad_nxt;      // padding spilled into a further block
  logic [2:0] idx_r, idx_nxt;
  logic       accept;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_idx   = idx_r;

  always_comb begin
    state_nxt = state_r;
    fin_nxt   = fin_r;
    last_nxt  = last_r;
    pad_nxt   = pad_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    cmd.src   = SRC_MSG;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_data.has_byte) begin
            cmd.put_byte   = 1'b1;
            cmd.count_byte = 1'b1;
            if (sts.fill == 6'd63) begin
              cmd.comp_start = 1'b1;
              fin_nxt        = 1'b0;
              last_nxt       = in_data.is_last;
              state_nxt      = S_ROUND;
            end else if (in_data.is_last) begin
              state_nxt = S_PAD;
            end
          end else if (in_data.is_last) begin
            state_nxt = S_PAD;
          end
        end
      end
      S_ROUND: begin
        cmd.round_step = 1'b1;
        if (sts.rnd == 6'd63) state_nxt = S_FOLD;
      end
      S_FOLD: begin
        cmd.comp_fold = 1'b1;
        if (fin_r) begin
          state_nxt = S_OUT;
          idx_nxt   = '0;
        end else if (pad_r) begin
          pad_nxt   = 1'b0;
          state_nxt = S_ZERO;
        end else if (last_r) begin
          last_nxt  = 1'b0;
          state_nxt = S_PAD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_PAD: begin
        cmd.put_byte = 1'b1;
        cmd.src      = SRC_PAD;
        if (sts.fill == 6'd63) begin
          cmd.comp_start = 1'b1;
          pad_nxt        = 1'b1;
          state_nxt      = S_ROUND;
        end else if (sts.fill == LenPos - 6'd1) begin
          state_nxt = S_LEN;
        end else begin
          state_nxt = S_ZERO;
        end
      end
      S_ZERO: begin
        if (sts.fill == LenPos) begin
          state_nxt = S_LEN;
        end else begin
          cmd.put_byte = 1'b1;
          cmd.src      = SRC_ZERO;
          if (sts.fill == 6'd63) begin
            cmd.comp_start = 1'b1;
            pad_nxt        = 1'b1;
            state_nxt      = S_ROUND;
          end
        end
      end
      S_LEN: begin
        cmd.put_len    = 1'b1;
        cmd.comp_start = 1'b1;
        fin_nxt        = 1'b1;
        state_nxt      = S_ROUND;
      end
      S_OUT: begin
        if (!out_stall) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == 3'd7) begin
            cmd.msg_init = 1'b1;
            fin_nxt      = 1'b0;
            state_nxt    = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fin_r   <= 1'b0;
      last_r  <= 1'b0;
      pad_r   <= 1'b0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      fin_r   <= fin_nxt;
      last_r  <= last_nxt;
      pad_r   <= pad_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: src/sha_dp.sv
// ----------------------------------------------------------------------------
// sha_dp
// Datapath: block buffer, message schedule window, round unit, hash words.
// ----------------------------------------------------------------------------
`default_nettype none
module sha_dp (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [7:0]        msg_byte,
  input  wire sha_pkg::sha_cmd_t cmd,
  input  wire logic [2:0]        out_idx,
  output sha_pkg::sha_sts_t      sts,
  output logic [31:0]            digest_word
);
  import sha_pkg::*;

  logic [31:0] blk_r    [16];
  logic [31:0] blk_view [16];
  logic [31:0] win_r    [16];
  logic [31:0] win_nxt  [16];
  logic [31:0] hash_r   [NumHash];
  logic [31:0] v_r      [NumHash];
  logic [5:0]  fill_r;
  logic [5:0]  rnd_r;
  logic [LenW-1:0] total_r;
  logic [7:0]  byte_in;
  logic [31:0] w_new, t1, t2;
  logic [LenW-1:0] bits;

  assign sts.fill    = fill_r;
  assign sts.rnd     = rnd_r;
  assign digest_word = hash_r[out_idx];
  assign bits        = {total_r[LenW-4:0], 3'b000};

  always_comb begin
    case (cmd.src)
      SRC_MSG:  byte_in = msg_byte;
      SRC_PAD:  byte_in = PadByte;
      SRC_ZERO: byte_in = 8'h00;
      default:  byte_in = 8'h00;
    endcase
  end

  // the byte or length written this cycle lands in the window too
  always_comb begin
    for (int i = 0; i < 16; i++) blk_view[i] = blk_r[i];
    if (cmd.put_byte) blk_view[15] = {blk_r[15][31:8], byte_in};
    if (cmd.put_len) begin
      blk_view[14] = bits[63:32];
      blk_view[15] = bits[31:0];
    end
  end

  // schedule: window holds w[i..i+15]; new word appended each round
  assign w_new = win_r[0] + ssig0(win_r[1]) + win_r[9] + ssig1(win_r[14]);
  always_comb begin
    for (int i = 0; i < 15; i++) win_nxt[i] = win_r[i + 1];
    win_nxt[15] = w_new;
  end

  assign t1 = v_r[7] + bsig1(v_r[4]) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
            + RoundK[rnd_r] + win_r[0];
  assign t2 = bsig0(v_r[0]) + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));

  // block buffer, schedule window and working variables (payload, no reset)
  always_ff @(posedge clk) begin
    if (cmd.put_byte) begin
      case (fill_r[1:0])
        2'd0: blk_r[fill_r[5:2]][31:24] <= byte_in;
        2'd1: blk_r[fill_r[5:2]][23:16] <= byte_in;
        2'd2: blk_r[fill_r[5:2]][15:8]  <= byte_in;
        default: blk_r[fill_r[5:2]][7:0] <= byte_in;
      endcase
    end
    if (cmd.put_len) begin
      blk_r[14] <= bits[63:32];
      blk_r[15] <= bits[31:0];
    end
    if (cmd.comp_start) begin
      for (int i = 0; i < 16; i++) win_r[i] <= blk_view[i];
      for (int i = 0; i < NumHash; i++) v_r[i] <= hash_r[i];
    end else if (cmd.round_step) begin
      for (int i = 0; i < 16; i++) win_r[i] <= win_nxt[i];
      v_r[0] <= t1 + t2;
      v_r[1] <= v_r[0];
      v_r[2] <= v_r[1];
      v_r[3] <= v_r[2];
      v_r[4] <= v_r[3] + t1;
      v_r[5] <= v_r[4];
      v_r[6] <= v_r[5];
      v_r[7] <= v_r[6];
    end
  end

  // control-relevant state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      rnd_r   <= '0;
      total_r <= '0;
      for (int i = 0; i < NumHash; i++) hash_r[i] <= InitH[i];
    end else begin
      if (cmd.msg_init) begin
        fill_r  <= '0;
        total_r <= '0;
        for (int i = 0; i < NumHash; i++) hash_r[i] <= InitH[i];
      end else begin
        if (cmd.put_byte) fill_r <= fill_r + 6'd1;
        if (cmd.put_len)  fill_r <= '0;
        if (cmd.count_byte) total_r <= total_r + 64'd1;
        if (cmd.comp_fold) begin
          for (int i = 0; i < NumHash; i++) hash_r[i] <= hash_r[i] + v_r[i];
        end
      end
      if (cmd.comp_start)      rnd_r <= '0;
      else if (cmd.round_step) rnd_r <= rnd_r + 6'd1;
    end
  end

endmodule
`default_nettype wire

FILE: src/sha256_stream_hasher.sv
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// SHA-256 over a byte stream; emits the digest as eight 32-bit words.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  in_       in   in_valid/in_stall  msg_byte, has_byte, is_last
//  out_      out  out_valid/out_stall digest_word, word_index, last_word
//
//  a byte item is written straight into the block buffer; the byte that fills a
//  block adds the rounds and a fold on the single shared round unit.
//  a last item adds padding at one byte per cycle (held while a spilled block is
//  compressed, plus a check step when zeros reach byte 56), a length step,
//  one or two compressions, then eight output words.
//  in_stall is high from the cycle after a block-filling or last item until its work is done.
//  out_stall holds the current digest word; reset is synchronous, active low.
`default_nettype none
module sha256_stream_hasher (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire sha_pkg::in_item_t   in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output sha_pkg::out_item_t       out_data
);
  import sha_pkg::*;

  sha_cmd_t    cmd;
  sha_sts_t    sts;
  logic [2:0]  idx;
  logic [31:0] dword;

  sha_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .out_valid, .out_stall, .out_idx(idx), .cmd, .sts
  );

  sha_dp u_dp (
    .clk, .rst_n, .msg_byte(in_data.msg_byte), .cmd, .out_idx(idx),
    .sts, .digest_word(dword)
  );

  assign out_data.digest_word = dword;
  assign out_data.word_index  = idx;
  assign out_data.last_word   = (idx == 3'd7);

  a_no_both: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_valid && !in_stall)) else $error("idle while emitting");
  a_round_adv: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.round_step && !cmd.comp_start |=> sts.rnd == $past(sts.rnd) + 6'd1)
    else $error("round counter slip");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(idx))
    else $error("digest word moved under stall");

endmodule
`default_nettype wire
